@@ src/crcdf_pkg.sv @@
// shared types, constants and crc function for the crc16 frame deframer
package crcdf_pkg;

    localparam int MAX_PAYLOAD = 64;
    localparam int HDR_BYTES   = 6;
    localparam int PAY_AW      = $clog2(MAX_PAYLOAD);
    localparam int HDR_AW      = $clog2(HDR_BYTES);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_START_ONE = 2'd0,
        REG_START_TWO = 2'd1,
        REG_VERSION   = 2'd2
    } reg_idx_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_BAD_VERSION = 2'd1,
        ST_BAD_LENGTH  = 2'd2,
        ST_BAD_CRC     = 2'd3
    } frame_status_t;

    // what the output register is loaded with
    typedef enum logic [1:0] {
        OUT_ERR,
        OUT_EMPTY,
        OUT_PAYLOAD
    } out_sel_t;

    typedef enum logic [3:0] {
        S_HUNT,
        S_SYNC,
        S_HDR,
        S_PAY,
        S_CRC_LO,
        S_CRC_HI,
        S_EMIT_RD,
        S_EMIT_LD
    } state_t;

    typedef struct packed {
        logic [7:0] start_one;
        logic [7:0] start_two;
        logic [7:0] version;
    } cfg_t;

    typedef struct packed {
        logic          cnt_clr;
        logic          cnt_inc;
        logic          crc_init;
        logic          crc_feed;
        logic          hdr_wr;
        logic          plen_load;
        logic          pay_wr;
        logic          crclo_wr;
        logic          rd_issue;
        logic          out_load;
        out_sel_t      out_sel;
        frame_status_t err_code;
    } dp_cmd_t;

    typedef struct packed {
        logic start_one_hit;
        logic start_two_hit;
        logic hdr_last;
        logic ver_ok;
        logic len_ok;
        logic hdr_len_zero;
        logic plen_zero;
        logic cnt_at_end;
        logic crc_ok;
        logic out_free;
    } dp_sts_t;

    // crc-16/modbus update with one byte, reflected
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

@@ src/crcdf_dpath.sv @@
// datapath: counter, header registers, payload memory, crc and output register
module crcdf_dpath (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  crcdf_pkg::cfg_t         cfg,
    input  crcdf_pkg::dp_cmd_t      cmd,
    output crcdf_pkg::dp_sts_t      sts,
    input  logic [7:0]              rx_byte,
    input  logic                    m_ready,
    output logic                    m_valid,
    output logic [1:0]              m_status,
    output logic [7:0]              m_msg_type,
    output logic [15:0]             m_sequence_res,
    output logic [6:0]              m_pay_len,
    output logic [7:0]              m_payload_byte,
    output logic [5:0]              m_byte_index,
    output logic                    m_last
);
    import crcdf_pkg::*;

    logic [PAY_AW-1:0] cnt_reg;
    logic [15:0]       crc_reg;
    logic [7:0]        hdr_reg [HDR_BYTES];
    logic [6:0]        plen_reg;
    logic [7:0]        crclo_reg;
    logic [7:0]        pay_mem [MAX_PAYLOAD];
    logic [7:0]        rd_data_reg;

    logic              m_valid_reg;
    logic [1:0]        status_reg;
    logic [7:0]        type_reg;
    logic [15:0]       seq_reg;
    logic [6:0]        len_reg;
    logic [7:0]        byte_reg;
    logic [5:0]        index_reg;
    logic              last_reg;

    logic [15:0]       len16;

    assign len16 = {rx_byte, hdr_reg[4]};

    always_comb begin
        sts.start_one_hit = (rx_byte == cfg.start_one);
        sts.start_two_hit = (rx_byte == cfg.start_two);
        sts.hdr_last      = (cnt_reg == PAY_AW'(HDR_BYTES - 1));
        sts.ver_ok        = (hdr_reg[0] == cfg.version);
        sts.len_ok        = (len16 <= 16'(MAX_PAYLOAD));
        sts.hdr_len_zero  = (len16 == 16'd0);
        sts.plen_zero     = (plen_reg == 7'd0);
        sts.cnt_at_end    = ((7'(cnt_reg) + 7'd1) == plen_reg);
        sts.crc_ok        = ({rx_byte, crclo_reg} == crc_reg);
        sts.out_free      = !m_valid_reg || m_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.cnt_clr) begin
            cnt_reg <= '0;
        end else if (cmd.cnt_inc) begin
            cnt_reg <= cnt_reg + PAY_AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= CRC_INIT;
        end else if (cmd.crc_init) begin
            crc_reg <= CRC_INIT;
        end else if (cmd.crc_feed) begin
            crc_reg <= crc16_byte(crc_reg, rx_byte);
        end
    end

    // payload side registers, no reset
    always_ff @(posedge aclk) begin
        if (cmd.hdr_wr) begin
            hdr_reg[cnt_reg[HDR_AW-1:0]] <= rx_byte;
        end
        if (cmd.plen_load) begin
            plen_reg <= len16[6:0];
        end
        if (cmd.crclo_wr) begin
            crclo_reg <= rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.pay_wr) begin
            pay_mem[cnt_reg] <= rx_byte;
        end
        if (cmd.rd_issue) begin
            rd_data_reg <= pay_mem[cnt_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            case (cmd.out_sel)
                OUT_PAYLOAD: begin
                    status_reg <= ST_OK;
                    type_reg   <= hdr_reg[1];
                    seq_reg    <= {hdr_reg[3], hdr_reg[2]};
                    len_reg    <= plen_reg;
                    byte_reg   <= rd_data_reg;
                    index_reg  <= 6'(cnt_reg);
                    last_reg   <= sts.cnt_at_end;
                end
                OUT_EMPTY: begin
                    status_reg <= ST_OK;
                    type_reg   <= hdr_reg[1];
                    seq_reg    <= {hdr_reg[3], hdr_reg[2]};
                    len_reg    <= 7'd0;
                    byte_reg   <= 8'd0;
                    index_reg  <= 6'd0;
                    last_reg   <= 1'b1;
                end
                default: begin
                    status_reg <= cmd.err_code;
                    type_reg   <= 8'd0;
                    seq_reg    <= 16'd0;
                    len_reg    <= 7'd0;
                    byte_reg   <= 8'd0;
                    index_reg  <= 6'd0;
                    last_reg   <= 1'b1;
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = status_reg;
    assign m_msg_type     = type_reg;
    assign m_sequence_res = seq_reg;
    assign m_pay_len      = len_reg;
    assign m_payload_byte = byte_reg;
    assign m_byte_index   = index_reg;
    assign m_last         = last_reg;

endmodule

@@ src/crcdf_ctrl.sv @@
// controller: frame parsing state machine
module crcdf_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  crcdf_pkg::dp_sts_t      sts,
    output crcdf_pkg::dp_cmd_t      cmd
);
    import crcdf_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_HUNT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.out_sel  = OUT_ERR;
        cmd.err_code = ST_OK;
        s_ready      = 1'b0;
        accept       = 1'b0;

        case (state_reg)
            S_HUNT: begin
                s_ready = sts.out_free;
                accept  = s_valid && s_ready;
                if (accept && sts.start_one_hit) begin
                    state_next = S_SYNC;
                end
            end
            S_SYNC: begin
                s_ready = sts.out_free;
                accept  = s_valid && s_ready;
                if (accept) begin
                    if (sts.start_two_hit) begin
                        cmd.crc_init = 1'b1;
                        cmd.cnt_clr  = 1'b1;
                        state_next   = S_HDR;
                    end else if (!sts.start_one_hit) begin
                        // not a start byte, so resume hunting
                        state_next = S_HUNT;
                    end
                end
            end
            S_HDR: begin
                s_ready = sts.out_free;
                accept  = s_valid && s_ready;
                if (accept) begin
                    cmd.hdr_wr   = 1'b1;
                    cmd.crc_feed = 1'b1;
                    cmd.cnt_inc  = 1'b1;
                    if (sts.hdr_last) begin
                        if (!sts.ver_ok) begin
                            cmd.out_load = 1'b1;
                            cmd.err_code = ST_BAD_VERSION;
                            state_next   = S_HUNT;
                        end else if (!sts.len_ok) begin
                            cmd.out_load = 1'b1;
                            cmd.err_code = ST_BAD_LENGTH;
                            state_next   = S_HUNT;
                        end else begin
                            cmd.plen_load = 1'b1;
                            cmd.cnt_clr   = 1'b1;
                            state_next    = sts.hdr_len_zero ? S_CRC_LO : S_PAY;
                        end
                    end
                end
            end
            S_PAY: begin
                s_ready = sts.out_free;
                accept  = s_valid && s_ready;
                if (accept) begin
                    cmd.pay_wr   = 1'b1;
                    cmd.crc_feed = 1'b1;
                    cmd.cnt_inc  = 1'b1;
                    if (sts.cnt_at_end) begin
                        state_next = S_CRC_LO;
                    end
                end
            end
            S_CRC_LO: begin
                s_ready = sts.out_free;
                accept  = s_valid && s_ready;
                if (accept) begin
                    cmd.crclo_wr = 1'b1;
                    state_next   = S_CRC_HI;
                end
            end
            S_CRC_HI: begin
                s_ready = sts.out_free;
                accept  = s_valid && s_ready;
                if (accept) begin
                    if (!sts.crc_ok) begin
                        cmd.out_load = 1'b1;
                        cmd.err_code = ST_BAD_CRC;
                        state_next   = S_HUNT;
                    end else if (sts.plen_zero) begin
                        cmd.out_load = 1'b1;
                        cmd.out_sel  = OUT_EMPTY;
                        state_next   = S_HUNT;
                    end else begin
                        cmd.cnt_clr = 1'b1;
                        state_next  = S_EMIT_RD;
                    end
                end
            end
            S_EMIT_RD: begin
                cmd.rd_issue = 1'b1;
                state_next   = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OUT_PAYLOAD;
                    cmd.cnt_inc  = 1'b1;
                    state_next   = sts.cnt_at_end ? S_HUNT : S_EMIT_RD;
                end
            end
            default: begin
                state_next = S_HUNT;
            end
        endcase
    end

    // a result is only loaded into a free output register
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded over a pending result");

    // every error result ends the frame
    a_err_hunt: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load && cmd.out_sel == OUT_ERR) |=> state_reg == S_HUNT)
        else $error("parser did not restart after error result");

    // no input is taken while a payload run is emitted
    a_emit_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT_RD || state_reg == S_EMIT_LD) |-> !s_ready)
        else $error("input accepted during emission");

    // the final emitted byte closes the run
    a_emit_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT_LD && cmd.out_load && sts.cnt_at_end) |=> state_reg == S_HUNT)
        else $error("emission ran past payload length");

endmodule

@@ src/crc16_frame_deframer.sv @@
// top level of the crc16 framed packet deframer
//
//  channel   dir  handshake           payload
//  s_        in   s_valid / s_ready   s_rx_byte
//  m_        out  m_valid / m_ready   m_status, m_msg_type, m_sequence_res,
//                                     m_pay_len, m_payload_byte,
//                                     m_byte_index, m_last
//  cfg_      in   cfg_wr_en           cfg_index, cfg_wr_data
//
// header, payload and crc bytes are taken one per cycle while the output
// register is free; the crc is updated with a whole header or payload byte in
// the cycle it is accepted; a good frame of n payload bytes emits n results,
// or one empty result if n is 0; no input is taken meanwhile
// synchronous active-low reset returns the parser to hunting and empties the
// output register; configuration goes back to 0xaa, 0x55 and version 1
// a result waiting in the output register holds off input until it is taken
module crc16_frame_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    // received byte requests
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    // result requests
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [7:0]  m_msg_type,
    output logic [15:0] m_sequence_res,
    output logic [6:0]  m_pay_len,
    output logic [7:0]  m_payload_byte,
    output logic [5:0]  m_byte_index,
    output logic        m_last,
    // configuration writes
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wr_data
);
    import crcdf_pkg::*;

    // configuration registers
    cfg_t    cfg_reg;
    dp_cmd_t cmd;
    dp_sts_t sts;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_one <= 8'hAA;
            cfg_reg.start_two <= 8'h55;
            cfg_reg.version   <= 8'h01;
        end else if (cfg_wr_en) begin
            // writes beyond the register list are dropped
            case (cfg_index)
                REG_START_ONE: cfg_reg.start_one <= cfg_wr_data;
                REG_START_TWO: cfg_reg.start_two <= cfg_wr_data;
                REG_VERSION:   cfg_reg.version   <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // parsing state machine
    crcdf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // counters, stores, crc and output register
    crcdf_dpath u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .cmd            (cmd),
        .sts            (sts),
        .rx_byte        (s_rx_byte),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_status       (m_status),
        .m_msg_type     (m_msg_type),
        .m_sequence_res (m_sequence_res),
        .m_pay_len      (m_pay_len),
        .m_payload_byte (m_payload_byte),
        .m_byte_index   (m_byte_index),
        .m_last         (m_last)
    );

endmodule
